>>> hw/rtl/handheld_console_memory_map_assert.svh
// ----------------------------------------------------------------------------
// handheld_console_memory_map_assert.svh
// Assertion macros used by the memory map top module.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_CONSOLE_MEMORY_MAP_ASSERT_SVH
`define HANDHELD_CONSOLE_MEMORY_MAP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define HCMM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("memory map assertion failed");

// next-cycle implication, disabled while in reset
`define HCMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("memory map assertion failed");

`endif

>>> hw/rtl/hcmm_pkg.sv
// ----------------------------------------------------------------------------
// hcmm_pkg
// Types and constants of the handheld console memory map.
// ----------------------------------------------------------------------------
package hcmm_pkg;

	localparam int DATA_W = 8;
	localparam int BUS_W  = 16;
	localparam int REG_W  = 4;

	// region codes
	localparam logic [REG_W-1:0] REG_ROM      = 4'd0;
	localparam logic [REG_W-1:0] REG_VRAM     = 4'd1;
	localparam logic [REG_W-1:0] REG_XRAM     = 4'd2;
	localparam logic [REG_W-1:0] REG_WRAM     = 4'd3;
	localparam logic [REG_W-1:0] REG_OAM      = 4'd4;
	localparam logic [REG_W-1:0] REG_UNUSABLE = 4'd5;
	localparam logic [REG_W-1:0] REG_IO       = 4'd6;
	localparam logic [REG_W-1:0] REG_HRAM     = 4'd7;
	localparam logic [REG_W-1:0] REG_IE       = 4'd8;

	// region upper bounds (inclusive)
	localparam logic [BUS_W-1:0] TOP_ROM      = 16'h7FFF;
	localparam logic [BUS_W-1:0] TOP_VRAM     = 16'h9FFF;
	localparam logic [BUS_W-1:0] TOP_XRAM     = 16'hBFFF;
	localparam logic [BUS_W-1:0] TOP_WRAM     = 16'hDFFF;
	localparam logic [BUS_W-1:0] TOP_ECHO     = 16'hFDFF;
	localparam logic [BUS_W-1:0] TOP_OAM      = 16'hFE9F;
	localparam logic [BUS_W-1:0] TOP_UNUSABLE = 16'hFEFF;
	localparam logic [BUS_W-1:0] TOP_IO       = 16'hFF7F;
	localparam logic [BUS_W-1:0] TOP_HRAM     = 16'hFFFE;

	// video unit modes that lock the sprite table
	localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
	localparam logic [1:0] MODE_DRAW     = 2'd3;

	localparam logic [DATA_W-1:0] BYTE_LOCKED = 8'hFF;

	typedef struct packed {
		logic [REG_W-1:0] region;
		logic             locked;  // sprite table locked by video unit
		logic             wr_ok;   // write beat lands in a store
	} dec_t;

endpackage

>>> hw/rtl/hcmm_decode.sv
// ----------------------------------------------------------------------------
// hcmm_decode
// Address decode: region, sprite lock and write permission of one beat.
// ----------------------------------------------------------------------------
module hcmm_decode import hcmm_pkg::*; (
	input  logic [BUS_W-1:0] address,
	input  logic             action,
	input  logic [1:0]       ppu_mode,
	input  logic             rom_writable,
	output dec_t             dec
);

	logic [REG_W-1:0] region;
	logic             locked;

	assign locked = (ppu_mode == MODE_OAM_SCAN) || (ppu_mode == MODE_DRAW);

	always_comb begin
		if (address <= TOP_ROM)           region = REG_ROM;
		else if (address <= TOP_VRAM)     region = REG_VRAM;
		else if (address <= TOP_XRAM)     region = REG_XRAM;
		else if (address <= TOP_ECHO)     region = REG_WRAM;  // echo mirrors work RAM
		else if (address <= TOP_OAM)      region = REG_OAM;
		else if (address <= TOP_UNUSABLE) region = REG_UNUSABLE;
		else if (address <= TOP_IO)       region = REG_IO;
		else if (address <= TOP_HRAM)     region = REG_HRAM;
		else                              region = REG_IE;
	end

	always_comb begin
		dec.region = region;
		dec.locked = locked;
		unique case (region)
			REG_ROM:      dec.wr_ok = action && rom_writable;
			REG_OAM:      dec.wr_ok = action && !locked;
			REG_UNUSABLE: dec.wr_ok = 1'b0;
			default:      dec.wr_ok = action;
		endcase
	end

endmodule

>>> hw/rtl/hcmm_ram.sv
// ----------------------------------------------------------------------------
// hcmm_ram
// Single-port byte RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
module hcmm_ram import hcmm_pkg::*; #(
	parameter int DEPTH = 8192,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[idx] <= wdata;
			else    rdata    <= mem[idx];
		end
	end

endmodule

>>> hw/rtl/handheld_console_memory_map.sv
// ----------------------------------------------------------------------------
// handheld_console_memory_map
// CPU bus memory map: decodes each beat onto ROM, video/external/work RAM,
// sprite table, I/O registers, high RAM and interrupt enable.
// ----------------------------------------------------------------------------
// A read beat returns read_data with done in the cycle after start, taken
// from the registered read port of each store RAM.
// Throughput: one beat per cycle while busy is low, reads and writes in any mix.
// done lasts one cycle; the receiver cannot stall.
// Reset: busy is high during reset and until the first clock edge after
// release; I/O registers read zero (valid bits cleared), interrupt enable zero.
// ----------------------------------------------------------------------------
`include "handheld_console_memory_map_assert.svh"

module handheld_console_memory_map import hcmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [BUS_W-1:0]  address,
	input  logic [DATA_W-1:0] write_data,
	input  logic [1:0]        ppu_mode,
	// result
	output logic              done,
	output logic [DATA_W-1:0] read_data,
	// config
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	localparam int IO_DEPTH = 128;
	localparam int IO_IDX_W = $clog2(IO_DEPTH);

	logic rom_writable_q;
	logic busy_q;
	logic acc;
	dec_t dec;

	// stage 1 (read beat in flight)
	logic              done_s1;
	logic [REG_W-1:0]  region_s1;
	logic              locked_s1;
	logic [DATA_W-1:0] fill_s1;
	logic              io_vld_s1;

	logic [DATA_W-1:0] ie_q;
	logic [IO_DEPTH-1:0] io_vld_q;

	logic [DATA_W-1:0] rom_rd, vram_rd, xram_rd, wram_rd, oam_rd, io_rd, hram_rd;
	logic              rd_beat;
	logic [IO_IDX_W-1:0] io_idx;

	assign busy    = busy_q;
	assign acc     = start && !busy_q;
	assign rd_beat = acc && !action;
	assign io_idx  = address[IO_IDX_W-1:0];

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rom_writable_q <= 1'b0;
		else if (cfg_we) rom_writable_q <= cfg_wdata;
	end

	// hold off beats through reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b1;
		else         busy_q <= 1'b0;
	end

	hcmm_decode u_decode (
		.address      (address),
		.action       (action),
		.ppu_mode     (ppu_mode),
		.rom_writable (rom_writable_q),
		.dec          (dec)
	);

	// one enable per store: reads always except locked sprite table reads, writes only when permitted
	function automatic logic hit(input dec_t d, input logic [REG_W-1:0] r, input logic a,
			input logic rd);
		return (d.region == r) && a && (rd || d.wr_ok);
	endfunction

	hcmm_ram #(.DEPTH(32768)) u_rom (
		.clk(clk), .en(hit(dec, REG_ROM, acc, !action)), .we(action),
		.idx(address[14:0]), .wdata(write_data), .rdata(rom_rd)
	);

	hcmm_ram #(.DEPTH(8192)) u_vram (
		.clk(clk), .en(hit(dec, REG_VRAM, acc, !action)), .we(action),
		.idx(address[12:0]), .wdata(write_data), .rdata(vram_rd)
	);

	hcmm_ram #(.DEPTH(8192)) u_xram (
		.clk(clk), .en(hit(dec, REG_XRAM, acc, !action)), .we(action),
		.idx(address[12:0]), .wdata(write_data), .rdata(xram_rd)
	);

	// work RAM and its echo share the low 13 address bits
	hcmm_ram #(.DEPTH(8192)) u_wram (
		.clk(clk), .en(hit(dec, REG_WRAM, acc, !action)), .we(action),
		.idx(address[12:0]), .wdata(write_data), .rdata(wram_rd)
	);

	// locked reads skip the RAM; the output mux forces 0xFF
	hcmm_ram #(.DEPTH(160)) u_oam (
		.clk(clk), .en(hit(dec, REG_OAM, acc, !action && !dec.locked)), .we(action),
		.idx(address[7:0]), .wdata(write_data), .rdata(oam_rd)
	);

	hcmm_ram #(.DEPTH(IO_DEPTH)) u_io (
		.clk(clk), .en(hit(dec, REG_IO, acc, !action)), .we(action),
		.idx(io_idx), .wdata(write_data), .rdata(io_rd)
	);

	hcmm_ram #(.DEPTH(127)) u_hram (
		.clk(clk), .en(hit(dec, REG_HRAM, acc, !action)), .we(action),
		.idx(address[6:0]), .wdata(write_data), .rdata(hram_rd)
	);

	// I/O registers reset to zero: one valid bit per entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_vld_q <= '0;
		end else if (hit(dec, REG_IO, acc, 1'b0)) begin
			io_vld_q[io_idx] <= 1'b1;
		end
	end

	// interrupt enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ie_q <= '0;
		else if (hit(dec, REG_IE, acc, 1'b0)) ie_q <= write_data;
	end

	// read beat tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s1 <= 1'b0;
		else         done_s1 <= rd_beat;
	end

	always_ff @(posedge clk) begin
		if (rd_beat) begin
			region_s1 <= dec.region;
			locked_s1 <= dec.locked;
			fill_s1   <= {address[7:4], address[7:4]};
			io_vld_s1 <= io_vld_q[io_idx];
		end
	end

	// result mux over registered RAM outputs
	always_comb begin
		unique case (region_s1)
			REG_ROM:      read_data = rom_rd;
			REG_VRAM:     read_data = vram_rd;
			REG_XRAM:     read_data = xram_rd;
			REG_WRAM:     read_data = wram_rd;
			REG_OAM:      read_data = locked_s1 ? BYTE_LOCKED : oam_rd;
			REG_UNUSABLE: read_data = locked_s1 ? BYTE_LOCKED : fill_s1;
			REG_IO:       read_data = io_vld_s1 ? io_rd : '0;
			REG_HRAM:     read_data = hram_rd;
			default:      read_data = ie_q;
		endcase
	end

	assign done = done_s1;

	`HCMM_ASSERT_NEXT(a_read_done, clk, arst_n, start && !busy && !action, done)
	`HCMM_ASSERT_NEXT(a_write_silent, clk, arst_n, start && !busy && action, !done)
	`HCMM_ASSERT_SAME(a_locked_ff, clk, arst_n,
		done && locked_s1 && (region_s1 == REG_OAM || region_s1 == REG_UNUSABLE),
		read_data == BYTE_LOCKED)
	`HCMM_ASSERT_SAME(a_ie_read, clk, arst_n, done && region_s1 == REG_IE, read_data == ie_q)

endmodule
